### rtl/amcc_pkg.sv
// Package for the argmax classifier: widths, constants, register codes,
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package amcc_pkg;

   localparam int SCORE_W         = 16;
   localparam int SUM_W           = 24;
   localparam int IDX_W           = 8;
   localparam int CONF_W          = 16;
   localparam int QUO_W           = 16;
   localparam int MODE_W          = 2;
   localparam int THR_W           = 16;
   localparam int DATA_W          = 32;
   localparam int ADDR_W          = 3;
   localparam int MAX_CLASSES_DEF = 256;

   // quotient bits after the first compare
   localparam int DIV_STEPS = QUO_W - 1;
   localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

   localparam logic [SCORE_W-1:0] Q_ONE         = SCORE_W'(32768);
   localparam logic [THR_W-1:0]   THRESHOLD_RST = THR_W'(16384);

   // register index = paddr word bit
   localparam logic REG_MODE      = 1'b0;
   localparam logic REG_THRESHOLD = 1'b1;

   localparam logic [MODE_W-1:0] MODE_MAX_VALUE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAX_CORRECT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALL_CORRECT = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [THR_W-1:0]  threshold;
   } cfg_type;

   typedef struct packed {
      logic accept;     // take one input word
      logic div_load;   // first quotient bit, set up remainder
      logic div_step;   // one restoring step
      logic finish;     // load result register, clear vector state
   } cmd_type;

   typedef struct packed {
      logic div_last;   // final division step in progress
      logic out_free;   // result register can take a word this cycle
   } status_type;

endpackage

`default_nettype wire

### rtl/amcc_req_if.sv
// Input channel: one score word with its good bit and last marker.
// Uses amcc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface amcc_req_if;
   logic                             valid;
   logic                             ready;
   logic [amcc_pkg::SCORE_W-1:0]     score;
   logic                             good_bit;
   logic                             last;

   modport source (output valid, output score, output good_bit, output last, input ready);
   modport sink   (input valid, input score, input good_bit, input last, output ready);
endinterface

`default_nettype wire

### rtl/amcc_rsp_if.sv
// Result channel: class, confidence and verdict flags, one word per vector.
// Uses amcc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface amcc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [amcc_pkg::IDX_W-1:0]      class_index;
   logic [amcc_pkg::CONF_W-1:0]     confidence;
   logic                            is_correct;
   logic                            zero_sum;
   logic                            overflow;

   modport source (output valid, output class_index, output confidence, output is_correct,
                   output zero_sum, output overflow, input ready);
   modport sink   (input valid, input class_index, input confidence, input is_correct,
                   input zero_sum, input overflow, output ready);
endinterface

`default_nettype wire

### rtl/argmax_classify_and_check.sv
// Argmax classifier: scores are taken one word per cycle while a vector streams in.
// After the last word: a setup step for the first quotient bit, the restoring divider
// steps, and a hand-off that waits for the result register to drain. The next
// vector's first word is taken the cycle after hand-off (divider and output stalls set the gap).
// Synchronous active-high reset clears vector state and the result valid flag;
// mode resets to max value, threshold to 0.5.
`timescale 1ns / 1ps
`default_nettype none

module argmax_classify_and_check #(
   parameter int MAX_CLASSES = amcc_pkg::MAX_CLASSES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   amcc_req_if.sink                           req_if,
   amcc_rsp_if.source                         rsp_if,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [amcc_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [amcc_pkg::DATA_W-1:0]   csr_pwdata,
   output logic      [amcc_pkg::DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready
);

   amcc_pkg::cfg_type    cfg;
   amcc_pkg::cmd_type    cmd;
   amcc_pkg::status_type status;

   amcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   amcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   amcc_dp #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_score       (req_if.score),
      .req_good_bit    (req_if.good_bit),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_class_index (rsp_if.class_index),
      .rsp_confidence  (rsp_if.confidence),
      .rsp_is_correct  (rsp_if.is_correct),
      .rsp_zero_sum    (rsp_if.zero_sum),
      .rsp_overflow    (rsp_if.overflow)
   );

endmodule

`default_nettype wire

### rtl/amcc_csr.sv
// APB-style register file: mode and threshold.
// Uses amcc_pkg for widths, reset values and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module amcc_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [amcc_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [amcc_pkg::DATA_W-1:0]   csr_pwdata,
   output logic      [amcc_pkg::DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready,
   output amcc_pkg::cfg_type                  cfg
);

   logic [amcc_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [amcc_pkg::THR_W-1:0]  thr_ff, thr_in;
   logic                        wr;

   assign wr         = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      thr_in  = thr_ff;
      if (wr) begin
         unique case (csr_paddr[2])
            amcc_pkg::REG_MODE:      mode_in = csr_pwdata[amcc_pkg::MODE_W-1:0];
            amcc_pkg::REG_THRESHOLD: thr_in  = csr_pwdata[amcc_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         amcc_pkg::REG_MODE:
            csr_prdata = {{(amcc_pkg::DATA_W-amcc_pkg::MODE_W){1'b0}}, mode_ff};
         amcc_pkg::REG_THRESHOLD:
            csr_prdata = {{(amcc_pkg::DATA_W-amcc_pkg::THR_W){1'b0}}, thr_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= amcc_pkg::MODE_MAX_VALUE;
         thr_ff  <= amcc_pkg::THRESHOLD_RST;
      end else begin
         mode_ff <= mode_in;
         thr_ff  <= thr_in;
      end
   end

   assign cfg.mode      = mode_ff;
   assign cfg.threshold = thr_ff;

endmodule

`default_nettype wire

### rtl/amcc_ctrl.sv
// Controller: accumulate, divide, hand off result word.
// Uses amcc_pkg command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module amcc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_last,
   output logic                      req_ready,
   input  amcc_pkg::status_type      status,
   output amcc_pkg::cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_ACCUM    = 4'b0001,
      ST_DIV_LOAD = 4'b0010,
      ST_DIV_RUN  = 4'b0100,
      ST_FINISH   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_ACCUM);

   always_comb begin
      state_in     = state_ff;
      cmd.accept   = 1'b0;
      cmd.div_load = 1'b0;
      cmd.div_step = 1'b0;
      cmd.finish   = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            cmd.accept = req_valid;
            if (req_valid && req_last) state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the result register to drain
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/amcc_dp.sv
// Datapath: running max/sum/match, restoring divider, result register.
// Uses amcc_pkg; driven by amcc_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module amcc_dp #(
   parameter int MAX_CLASSES = amcc_pkg::MAX_CLASSES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  amcc_pkg::cfg_type                   cfg,
   input  amcc_pkg::cmd_type                   cmd,
   output amcc_pkg::status_type                status,
   input  wire logic [amcc_pkg::SCORE_W-1:0]   req_score,
   input  wire logic                           req_good_bit,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [amcc_pkg::IDX_W-1:0]     rsp_class_index,
   output logic      [amcc_pkg::CONF_W-1:0]    rsp_confidence,
   output logic                                rsp_is_correct,
   output logic                                rsp_zero_sum,
   output logic                                rsp_overflow
);

   localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
   localparam int SW     = amcc_pkg::SCORE_W;
   localparam int SUMW   = amcc_pkg::SUM_W;
   localparam int QW     = amcc_pkg::QUO_W;
   localparam int DCW    = amcc_pkg::DCNT_W;

   // vector state
   logic [SW-1:0]                  best_ff, best_in;
   logic [amcc_pkg::IDX_W-1:0]     bidx_ff, bidx_in;
   logic                           bgood_ff, bgood_in;
   logic [SUMW-1:0]                sum_ff, sum_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           match_ff, match_in;
   logic                           over_ff, over_in;
   // divider
   logic [SUMW-1:0]                rem_ff, rem_in;
   logic [QW-1:0]                  quo_ff, quo_in;
   logic [DCW-1:0]                 dcnt_ff, dcnt_in;
   // result register
   logic                           ovalid_ff, ovalid_in;
   logic [amcc_pkg::IDX_W-1:0]     ocls_ff, ocls_in;
   logic [amcc_pkg::CONF_W-1:0]    oconf_ff, oconf_in;
   logic                           ocorr_ff, ocorr_in;
   logic                           ozero_ff, ozero_in;
   logic                           oover_ff, oover_in;

   logic                           pass_in, pass_best;
   logic [SUMW:0]                  rem_x2, diff;
   logic [SUMW:0]                  best_ext, ldiff;
   logic                           ge, lge;

   assign status.div_last = (dcnt_ff == DCW'(1));
   assign status.out_free = ~ovalid_ff | rsp_ready;

   assign pass_in   = (req_score >= cfg.threshold);
   assign pass_best = (best_ff >= cfg.threshold);

   // one restoring step; remainder stays below the divisor
   assign rem_x2   = {rem_ff, 1'b0};
   assign diff     = rem_x2 - {1'b0, sum_ff};
   assign ge       = ~diff[SUMW];
   assign best_ext = {{(SUMW+1-SW){1'b0}}, best_ff};
   assign ldiff    = best_ext - {1'b0, sum_ff};
   assign lge      = ~ldiff[SUMW];

   always_comb begin
      best_in   = best_ff;
      bidx_in   = bidx_ff;
      bgood_in  = bgood_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      match_in  = match_ff;
      over_in   = over_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;
      ovalid_in = ovalid_ff & ~rsp_ready;
      ocls_in   = ocls_ff;
      oconf_in  = oconf_ff;
      ocorr_in  = ocorr_ff;
      ozero_in  = ozero_ff;
      oover_in  = oover_ff;

      if (cmd.accept) begin
         if (cnt_ff < CNT_W'(MAX_CLASSES)) begin
            if (cnt_ff == '0 || req_score > best_ff) begin
               best_in  = req_score;
               bidx_in  = amcc_pkg::IDX_W'(cnt_ff);
               bgood_in = req_good_bit;
            end
            sum_in = sum_ff + SUMW'(req_score);
            if (req_good_bit != pass_in) match_in = 1'b0;
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            over_in = 1'b1;
         end
      end

      if (cmd.div_load) begin
         rem_in  = lge ? ldiff[SUMW-1:0] : best_ext[SUMW-1:0];
         quo_in  = {{(QW-1){1'b0}}, lge};
         dcnt_in = DCW'(amcc_pkg::DIV_STEPS);
      end

      if (cmd.div_step) begin
         rem_in  = ge ? diff[SUMW-1:0] : rem_x2[SUMW-1:0];
         quo_in  = {quo_ff[QW-2:0], ge};
         dcnt_in = dcnt_ff - DCW'(1);
      end

      if (cmd.finish) begin
         ovalid_in = 1'b1;
         oover_in  = over_ff;
         ozero_in  = 1'b0;
         if (cnt_ff == CNT_W'(1)) begin
            // single score: binary answer
            ocls_in = {{(amcc_pkg::IDX_W-1){1'b0}}, pass_best};
            if (pass_best)
               oconf_in = (best_ff > amcc_pkg::Q_ONE) ? amcc_pkg::Q_ONE : best_ff;
            else
               oconf_in = (best_ff >= amcc_pkg::Q_ONE) ? '0 : amcc_pkg::Q_ONE - best_ff;
         end else begin
            ocls_in = bidx_ff;
            if (sum_ff == '0) begin
               oconf_in = '0;
               ozero_in = 1'b1;
            end else begin
               oconf_in = (quo_ff > amcc_pkg::Q_ONE) ? amcc_pkg::Q_ONE : quo_ff;
            end
         end
         case (cfg.mode)
            amcc_pkg::MODE_MAX_VALUE:   ocorr_in = bgood_ff;
            amcc_pkg::MODE_MAX_CORRECT: ocorr_in = (bgood_ff == pass_best);
            default:                    ocorr_in = match_ff;
         endcase
         best_in  = '0;
         bidx_in  = '0;
         bgood_in = 1'b0;
         sum_in   = '0;
         cnt_in   = '0;
         match_in = 1'b1;
         over_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff   <= '0;
         bidx_ff   <= '0;
         bgood_ff  <= 1'b0;
         sum_ff    <= '0;
         cnt_ff    <= '0;
         match_ff  <= 1'b1;
         over_ff   <= 1'b0;
         dcnt_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         best_ff   <= best_in;
         bidx_ff   <= bidx_in;
         bgood_ff  <= bgood_in;
         sum_ff    <= sum_in;
         cnt_ff    <= cnt_in;
         match_ff  <= match_in;
         over_ff   <= over_in;
         dcnt_ff   <= dcnt_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      ocls_ff  <= ocls_in;
      oconf_ff <= oconf_in;
      ocorr_ff <= ocorr_in;
      ozero_ff <= ozero_in;
      oover_ff <= oover_in;
   end

   assign rsp_valid       = ovalid_ff;
   assign rsp_class_index = ocls_ff;
   assign rsp_confidence  = oconf_ff;
   assign rsp_is_correct  = ocorr_ff;
   assign rsp_zero_sum    = ozero_ff;
   assign rsp_overflow    = oover_ff;

endmodule

`default_nettype wire
